// File: rtl/prt_pkg.sv
// ----------------------------------------------------------------------------
// Pending request tracker package
// Shared widths, status codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package prt_pkg;

    localparam int SLOTS_DEF       = 8;
    localparam int MAX_PAYLOAD_DEF = 256;

    localparam int TXN_W  = 32;
    localparam int TAG_W  = 16;
    localparam int STAT_W = 3;

    localparam logic [TXN_W-1:0] TXN_INIT = 32'd1;

    // Call outcome codes.
    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_TOO_LONG = 3'd1;
    localparam logic [STAT_W-1:0] ST_NO_CB    = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STAT_W-1:0] ST_BUSY     = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              capture;
        logic              take_id;
        logic              scan_start;
        logic              scan_step;
        logic              sel_match_rd;
        logic              wr_slot;
        logic              free_match;
        logic              set_status;
        logic [STAT_W-1:0] status;
        logic              load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mode;
        logic too_long;
        logic no_cb;
        logic scan_done;
        logic free_found;
        logic match_found;
        logic queue_ready;
        logic out_free;
    } t_dp_stat;

endpackage

// File: rtl/prt_ctrl.sv
// ----------------------------------------------------------------------------
// Pending request tracker controller
// Sequences capture, checks, the slot scan, the table update and the result.
// ----------------------------------------------------------------------------
module prt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  prt_pkg::t_dp_stat  i_stat,
    output prt_pkg::t_dp_cmd   o_cmd,
    output logic               o_idle
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (i_stat.mode) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end else if (i_stat.too_long) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = prt_pkg::ST_TOO_LONG;
                    n_state          = S_RESULT;
                end else if (i_stat.no_cb) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = prt_pkg::ST_NO_CB;
                    n_state          = S_RESULT;
                end else begin
                    o_cmd.take_id    = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                // The read port moves to the matched slot so its data is ready next cycle.
                o_cmd.sel_match_rd = 1'b1;
                priority if (i_stat.mode) begin
                    n_state = i_stat.match_found ? S_RESULT : S_IDLE;
                end else if (!i_stat.free_found) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = prt_pkg::ST_FULL;
                    n_state          = S_RESULT;
                end else begin
                    o_cmd.wr_slot    = 1'b1;
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = i_stat.queue_ready ? prt_pkg::ST_OK : prt_pkg::ST_BUSY;
                    n_state          = S_RESULT;
                end
            end
            S_RESULT: begin
                o_cmd.sel_match_rd = 1'b1;
                if (i_stat.out_free) begin
                    o_cmd.load_out   = 1'b1;
                    o_cmd.free_match = i_stat.mode;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_idle = (r_state == S_IDLE);

endmodule

// File: rtl/prt_datapath.sv
// ----------------------------------------------------------------------------
// Pending request tracker datapath
// Holds the item, the id counter, the slot table and the output register.
// ----------------------------------------------------------------------------
module prt_datapath #(
    parameter int SLOTS       = prt_pkg::SLOTS_DEF,
    parameter int MAX_PAYLOAD = prt_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  prt_pkg::t_dp_cmd                 i_cmd,
    output prt_pkg::t_dp_stat                o_stat,
    input  logic                             i_mode,
    input  logic [prt_pkg::TAG_W-1:0]        i_method_code,
    input  logic [prt_pkg::TAG_W-1:0]        i_request_length,
    input  logic [prt_pkg::TAG_W-1:0]        i_callback_tag,
    input  logic [prt_pkg::TAG_W-1:0]        i_user_tag,
    input  logic                             i_queue_ready,
    input  logic [prt_pkg::TXN_W-1:0]        i_reply_id,
    input  logic signed [prt_pkg::TAG_W-1:0] i_reply_status,
    input  logic [prt_pkg::TAG_W-1:0]        i_reply_length,
    input  logic                             i_stall,
    output logic                             o_valid,
    output logic                             o_result_kind,
    output logic [prt_pkg::STAT_W-1:0]       o_call_status,
    output logic [prt_pkg::TXN_W-1:0]        o_txn_id,
    output logic [prt_pkg::TAG_W-1:0]        o_method_out,
    output logic [prt_pkg::TAG_W-1:0]        o_callback_out,
    output logic [prt_pkg::TAG_W-1:0]        o_user_out,
    output logic signed [prt_pkg::TAG_W-1:0] o_status_out,
    output logic [prt_pkg::TAG_W-1:0]        o_length_out
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ENT_W = prt_pkg::TXN_W + 3 * prt_pkg::TAG_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    // Captured item.
    logic                             r_mode;
    logic [prt_pkg::TAG_W-1:0]        r_method;
    logic [prt_pkg::TAG_W-1:0]        r_req_len;
    logic [prt_pkg::TAG_W-1:0]        r_cb;
    logic [prt_pkg::TAG_W-1:0]        r_user;
    logic                             r_qready;
    logic [prt_pkg::TXN_W-1:0]        r_reply_id;
    logic signed [prt_pkg::TAG_W-1:0] r_reply_status;
    logic [prt_pkg::TAG_W-1:0]        r_reply_len;

    logic [prt_pkg::TXN_W-1:0]  r_id;
    logic [prt_pkg::TXN_W-1:0]  r_next_txn;
    logic [prt_pkg::STAT_W-1:0] r_status;

    // Slot table: busy bits in flops, contents in a memory.
    logic [SLOTS-1:0] r_busy;
    logic [ENT_W-1:0] r_mem [SLOTS];
    logic [ENT_W-1:0] r_rd_data;
    logic [IDX_W-1:0] rd_addr;

    // Scan state.
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_cmp_idx;
    logic             r_cmp_vld;
    logic             r_free_found;
    logic [IDX_W-1:0] r_free_idx;
    logic             r_match_found;
    logic [IDX_W-1:0] r_match_idx;

    logic [prt_pkg::TXN_W-1:0] key;
    logic [prt_pkg::TXN_W-1:0] rd_txn;
    logic                      cmp_en;
    logic                      stale_lower;
    logic                      out_free;

    // Output register.
    logic                             r_out_vld;
    logic                             r_out_kind;
    logic [prt_pkg::STAT_W-1:0]       r_out_status;
    logic [prt_pkg::TXN_W-1:0]        r_out_txn;
    logic [prt_pkg::TAG_W-1:0]        r_out_method;
    logic [prt_pkg::TAG_W-1:0]        r_out_cb;
    logic [prt_pkg::TAG_W-1:0]        r_out_user;
    logic signed [prt_pkg::TAG_W-1:0] r_out_rstat;
    logic [prt_pkg::TAG_W-1:0]        r_out_rlen;

    assign key         = r_mode ? r_reply_id : r_id;
    assign rd_txn      = r_rd_data[ENT_W-1 -: prt_pkg::TXN_W];
    assign cmp_en      = i_cmd.scan_step && r_cmp_vld;
    assign rd_addr     = i_cmd.sel_match_rd ? r_match_idx : r_idx;
    assign out_free    = !r_out_vld || !i_stall;
    // Queue busy: a lower same-id busy slot is freed and the new slot taken.
    assign stale_lower = r_match_found && (r_match_idx < r_free_idx);

    always_comb begin
        o_stat             = '0;
        o_stat.mode        = r_mode;
        o_stat.too_long    = (r_req_len > prt_pkg::TAG_W'(MAX_PAYLOAD));
        o_stat.no_cb       = (r_cb == '0);
        o_stat.scan_done   = r_cmp_vld && (r_cmp_idx == LAST_IDX);
        o_stat.free_found  = r_free_found;
        o_stat.match_found = r_match_found;
        o_stat.queue_ready = r_qready;
        o_stat.out_free    = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode         <= i_mode;
            r_method       <= i_method_code;
            r_req_len      <= i_request_length;
            r_cb           <= i_callback_tag;
            r_user         <= i_user_tag;
            r_qready       <= i_queue_ready;
            r_reply_id     <= i_reply_id;
            r_reply_status <= i_reply_status;
            r_reply_len    <= i_reply_length;
        end
        if (i_cmd.capture) begin
            r_id <= '0;
        end else if (i_cmd.take_id) begin
            r_id <= r_next_txn;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_slot) begin
            r_mem[r_free_idx] <= {r_id, r_method, r_cb, r_user};
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_txn    <= prt_pkg::TXN_INIT;
            r_busy        <= '0;
            r_cmp_vld     <= 1'b0;
            r_free_found  <= 1'b0;
            r_match_found <= 1'b0;
        end else begin
            if (i_cmd.take_id) begin
                r_next_txn <= r_next_txn + 1'b1;
            end
            if (i_cmd.wr_slot) begin
                if (r_qready || stale_lower) begin
                    r_busy[r_free_idx] <= 1'b1;
                end
                if (!r_qready && stale_lower) begin
                    r_busy[r_match_idx] <= 1'b0;
                end
            end
            if (i_cmd.free_match) begin
                r_busy[r_match_idx] <= 1'b0;
            end
            if (i_cmd.scan_start) begin
                r_cmp_vld     <= 1'b0;
                r_free_found  <= 1'b0;
                r_match_found <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_cmp_vld <= 1'b1;
            end
            if (cmp_en) begin
                if (!r_free_found && !r_busy[r_cmp_idx]) begin
                    r_free_found <= 1'b1;
                end
                if (!r_match_found && r_busy[r_cmp_idx] && (rd_txn == key)) begin
                    r_match_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_idx <= '0;
        end else if (i_cmd.scan_step) begin
            r_cmp_idx <= r_idx;
            if (r_idx != LAST_IDX) begin
                r_idx <= r_idx + 1'b1;
            end
        end
        if (cmp_en) begin
            if (!r_free_found && !r_busy[r_cmp_idx]) begin
                r_free_idx <= r_cmp_idx;
            end
            if (!r_match_found && r_busy[r_cmp_idx] && (rd_txn == key)) begin
                r_match_idx <= r_cmp_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_kind <= r_mode;
            if (r_mode) begin
                r_out_status <= prt_pkg::ST_OK;
                r_out_txn    <= r_reply_id;
                r_out_method <= r_rd_data[3*prt_pkg::TAG_W-1 -: prt_pkg::TAG_W];
                r_out_cb     <= r_rd_data[2*prt_pkg::TAG_W-1 -: prt_pkg::TAG_W];
                r_out_user   <= r_rd_data[prt_pkg::TAG_W-1:0];
                r_out_rstat  <= r_reply_status;
                r_out_rlen   <= r_reply_len;
            end else begin
                r_out_status <= r_status;
                r_out_txn    <= r_id;
                r_out_method <= '0;
                r_out_cb     <= '0;
                r_out_user   <= '0;
                r_out_rstat  <= '0;
                r_out_rlen   <= '0;
            end
        end
    end

    assign o_valid        = r_out_vld;
    assign o_result_kind  = r_out_kind;
    assign o_call_status  = r_out_status;
    assign o_txn_id       = r_out_txn;
    assign o_method_out   = r_out_method;
    assign o_callback_out = r_out_cb;
    assign o_user_out     = r_out_user;
    assign o_status_out   = r_out_rstat;
    assign o_length_out   = r_out_rlen;

`ifndef SYNTHESIS
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> out_free)
        else $error("result loaded while the output register still holds an item");

    a_id_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take_id |=> (r_next_txn == $past(r_next_txn) + 1'b1))
        else $error("transaction id did not advance by one");

    a_slot_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_slot && r_qready) |=> r_busy[$past(r_free_idx)])
        else $error("accepted call did not mark its slot busy");

    a_reply_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.free_match |=> !r_busy[$past(r_match_idx)])
        else $error("delivered reply left its slot busy");
`endif

endmodule

// File: rtl/pending_request_tracker.sv
// ----------------------------------------------------------------------------
// Pending request tracker
// Table of outstanding calls: assigns ids, holds slots, matches replies.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake           Payload
// input     in         i_valid / o_stall   mode, call fields, reply fields
// result    out        o_valid / i_stall   kind, status, id, slot tags, reply
//
// A call rejected on length or callback goes from the checks straight to the result
// state and skips the scan; every other item passes through the scan, which reads
// one slot of the table memory per cycle, and a decide state before its result.
// The next item is accepted once the controller is back in idle; a reply that
// matches no slot gives no result and returns to idle after the decide state.
// One item is worked on at a time; o_stall is high until it finishes.
// A finished result waits in the output register while i_stall is high.
// Reset clears every busy bit at once and sets the next id to one.
// ----------------------------------------------------------------------------
module pending_request_tracker #(
    parameter int SLOTS       = prt_pkg::SLOTS_DEF,
    parameter int MAX_PAYLOAD = prt_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_mode,
    input  logic [prt_pkg::TAG_W-1:0]        i_method_code,
    input  logic [prt_pkg::TAG_W-1:0]        i_request_length,
    input  logic [prt_pkg::TAG_W-1:0]        i_callback_tag,
    input  logic [prt_pkg::TAG_W-1:0]        i_user_tag,
    input  logic                             i_queue_ready,
    input  logic [prt_pkg::TXN_W-1:0]        i_reply_id,
    input  logic signed [prt_pkg::TAG_W-1:0] i_reply_status,
    input  logic [prt_pkg::TAG_W-1:0]        i_reply_length,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_result_kind,
    output logic [prt_pkg::STAT_W-1:0]       o_call_status,
    output logic [prt_pkg::TXN_W-1:0]        o_txn_id,
    output logic [prt_pkg::TAG_W-1:0]        o_method_out,
    output logic [prt_pkg::TAG_W-1:0]        o_callback_out,
    output logic [prt_pkg::TAG_W-1:0]        o_user_out,
    output logic signed [prt_pkg::TAG_W-1:0] o_status_out,
    output logic [prt_pkg::TAG_W-1:0]        o_length_out
);

    prt_pkg::t_dp_cmd  cmd;
    prt_pkg::t_dp_stat stat;
    logic              idle;

    prt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_idle  (idle)
    );

    prt_datapath #(
        .SLOTS       (SLOTS),
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_mode           (i_mode),
        .i_method_code    (i_method_code),
        .i_request_length (i_request_length),
        .i_callback_tag   (i_callback_tag),
        .i_user_tag       (i_user_tag),
        .i_queue_ready    (i_queue_ready),
        .i_reply_id       (i_reply_id),
        .i_reply_status   (i_reply_status),
        .i_reply_length   (i_reply_length),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_result_kind    (o_result_kind),
        .o_call_status    (o_call_status),
        .o_txn_id         (o_txn_id),
        .o_method_out     (o_method_out),
        .o_callback_out   (o_callback_out),
        .o_user_out       (o_user_out),
        .o_status_out     (o_status_out),
        .o_length_out     (o_length_out)
    );

    assign o_stall = !idle;

endmodule
